### hw/rtl/snu_pkg.sv
`default_nettype none

package snu_pkg;

   // Fixed field widths of the hit and normal records
   localparam int CMD_WIDTH  = 3;
   localparam int VEC_WIDTH  = 63;
   localparam int DIST_WIDTH = 21;
   localparam int OUT_WIDTH  = 16;

   // Fraction bits of a unit normal component (Q1.14)
   localparam int NORM_FRAC = 14;

   // Defaults for the top-level parameters
   localparam int COORD_WIDTH_DEF = 21;
   localparam int FRAC_BITS_DEF   = 12;

   // Object kinds
   localparam logic [CMD_WIDTH-1:0] KIND_TRIANGLE = 3'd0;
   localparam logic [CMD_WIDTH-1:0] KIND_SPHERE   = 3'd1;
   localparam logic [CMD_WIDTH-1:0] KIND_PLANE    = 3'd2;
   localparam logic [CMD_WIDTH-1:0] KIND_CYLINDER = 3'd3;
   localparam logic [CMD_WIDTH-1:0] KIND_SQUARE   = 3'd4;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]  command;
      logic [VEC_WIDTH-1:0]  ray_direction;
      logic [VEC_WIDTH-1:0]  ray_origin;
      logic [VEC_WIDTH-1:0]  hit_point;
      logic [DIST_WIDTH-1:0] hit_distance;
      logic [VEC_WIDTH-1:0]  operand_a;
      logic [VEC_WIDTH-1:0]  operand_b;
      logic [VEC_WIDTH-1:0]  operand_c;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] normal_x;
      logic signed [OUT_WIDTH-1:0] normal_y;
      logic signed [OUT_WIDTH-1:0] normal_z;
      logic                        degenerate;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/surface_normal_unit.sv
`default_nettype none

// Surface normal unit.
// Input: one ray hit per transfer on req_data, taken at a clock edge with
// start high and busy low. busy is always low: a hit can be taken on every
// cycle, and hits stream through a fixed pipeline without blocking.
// Output: rsp_valid pulses for one cycle with the unit normal and the
// degenerate flag on rsp_data, in the order the hits were taken.
// Path: the input register, 3 cross-product stages, the axis normalizer,
// 6 cylinder projection stages, the final normalizer (a bit-per-stage
// square root and a bit-per-stage divider) and 2 facing/saturation stages.
// Throughput: one hit per cycle.
// Reset clears only the valid bits; hits in flight are dropped.
// The receiver cannot stall: every result is shown for exactly one cycle.
module surface_normal_unit #(
   parameter int COORD_WIDTH = snu_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = snu_pkg::FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire snu_pkg::req_type req_data,
   output logic                  rsp_valid,
   output snu_pkg::rsp_type      rsp_data
);

   localparam int CW   = COORD_WIDTH;
   localparam int CP1  = CW + 1;
   localparam int DW   = snu_pkg::DIST_WIDTH;
   localparam int NF   = snu_pkg::NORM_FRAC;
   localparam int OW   = snu_pkg::OUT_WIDTH;
   localparam int PW   = 2 * CP1;
   localparam int XW   = PW + 1;
   localparam int PD_W = CW + OW;
   localparam int PR_W = CP1 + OW;
   localparam int DA_W = PD_W + 2;
   localparam int RA_W = PR_W + 2;
   localparam int DT_W = DA_W + DW + 1;
   localparam int M_W  = DT_W + 1;
   localparam int MF_W = M_W - NF;
   localparam int PA_W = MF_W + OW;
   localparam int RW   = PA_W - NF + 1;
   localparam int VW2  = (XW > RW) ? XW : RW;
   localparam int UP   = (FRAC_BITS <= NF) ? (NF - FRAC_BITS) : 0;
   localparam int DN   = (FRAC_BITS > NF) ? (FRAC_BITS - NF) : 0;
   localparam int PQ_W = CW + 12;
   localparam int TP_W = CW + ((CW > OW) ? CW : OW);
   localparam int DOT_W = TP_W + 2;
   localparam logic signed [PQ_W:0] SAT_HI = (PQ_W + 1)'(32767);
   localparam logic signed [PQ_W:0] SAT_LO = -(PQ_W + 1)'(32768);

   typedef struct packed {
      logic [snu_pkg::CMD_WIDTH-1:0] kind;
      logic [2:0][CW-1:0]            dir;
      logic [2:0][CW-1:0]            b;
      logic [2:0][CP1-1:0]           hma;
      logic [2:0][CP1-1:0]           rel;
      logic [DW-1:0]                 t;
      logic [2:0][XW-1:0]            wx;
   } geo_type;

   typedef struct packed {
      logic [snu_pkg::CMD_WIDTH-1:0] kind;
      logic [2:0][CW-1:0]            dir;
      logic [2:0][CW-1:0]            b;
      logic                          deg1;
   } fin_type;

   logic accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // input register
   logic             t0_v_ff;
   snu_pkg::req_type req_ff;

   // stage 1: unpack and differences
   logic                  t1_v_ff;
   geo_type               t1_geo_ff, t1_geo_in;
   logic signed [CP1-1:0] t1_u_ff [3];
   logic signed [CP1-1:0] t1_u_in [3];
   logic signed [CP1-1:0] t1_w_ff [3];
   logic signed [CP1-1:0] t1_w_in [3];

   always_comb begin
      logic signed [CW-1:0] d_c, o_c, h_c, a_c, b_c, c_c;
      t1_geo_in      = '0;
      t1_geo_in.kind = req_ff.command;
      t1_geo_in.t    = req_ff.hit_distance;
      for (int i = 0; i < 3; i++) begin
         d_c = req_ff.ray_direction[i*CW +: CW];
         o_c = req_ff.ray_origin[i*CW +: CW];
         h_c = req_ff.hit_point[i*CW +: CW];
         a_c = req_ff.operand_a[i*CW +: CW];
         b_c = req_ff.operand_b[i*CW +: CW];
         c_c = req_ff.operand_c[i*CW +: CW];
         t1_geo_in.dir[i] = d_c;
         t1_geo_in.b[i]   = b_c;
         t1_geo_in.hma[i] = CP1'(h_c) - CP1'(a_c);
         t1_geo_in.rel[i] = CP1'(o_c) - CP1'(a_c);
         t1_u_in[i]       = CP1'(a_c) - CP1'(b_c);
         t1_w_in[i]       = CP1'(a_c) - CP1'(c_c);
      end
   end

   // stage 2: cross-product partial products
   logic                 t2_v_ff;
   geo_type              t2_geo_ff;
   logic signed [PW-1:0] t2_p_ff [6];
   logic signed [PW-1:0] t2_p_in [6];

   always_comb begin
      t2_p_in[0] = t1_u_ff[1] * t1_w_ff[2];
      t2_p_in[1] = t1_u_ff[2] * t1_w_ff[1];
      t2_p_in[2] = t1_u_ff[2] * t1_w_ff[0];
      t2_p_in[3] = t1_u_ff[0] * t1_w_ff[2];
      t2_p_in[4] = t1_u_ff[0] * t1_w_ff[1];
      t2_p_in[5] = t1_u_ff[1] * t1_w_ff[0];
   end

   // stage 3: cross product
   logic    t3_v_ff;
   geo_type t3_geo_ff, t3_geo_in;

   always_comb begin
      t3_geo_in = t2_geo_ff;
      for (int i = 0; i < 3; i++) begin
         t3_geo_in.wx[i] = XW'(t2_p_ff[2*i]) - XW'(t2_p_ff[2*i+1]);
      end
   end

   // cylinder axis normalizer
   logic signed [CW-1:0] n1_vec [3];
   logic                 n1_v;
   logic signed [OW-1:0] n1_ax [3];
   logic                 n1_zero;
   geo_type              n1_geo;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_vec[i] = t3_geo_ff.b[i];
      end
   end

   snu_norm #(
      .VEC_W  (CW),
      .SIDE_W ($bits(geo_type))
   ) u_norm_axis (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t3_v_ff),
      .in_vec    (n1_vec),
      .in_side   (t3_geo_ff),
      .out_valid (n1_v),
      .out_vec   (n1_ax),
      .out_zero  (n1_zero),
      .out_side  (n1_geo)
   );

   // C0: axis products
   logic                   c0_v_ff;
   geo_type                c0_geo_ff;
   logic                   c0_z_ff;
   logic signed [OW-1:0]   c0_ax_ff [3];
   logic signed [PD_W-1:0] c0_pd_ff [3];
   logic signed [PD_W-1:0] c0_pd_in [3];
   logic signed [PR_W-1:0] c0_pr_ff [3];
   logic signed [PR_W-1:0] c0_pr_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c0_pd_in[i] = $signed(n1_geo.dir[i]) * n1_ax[i];
         c0_pr_in[i] = $signed(n1_geo.rel[i]) * n1_ax[i];
      end
   end

   // C1: dot products D.V and (O-C).V
   logic                   c1_v_ff;
   geo_type                c1_geo_ff;
   logic                   c1_z_ff;
   logic signed [OW-1:0]   c1_ax_ff [3];
   logic signed [DA_W-1:0] c1_da_ff, c1_da_in;
   logic signed [RA_W-1:0] c1_ra_ff, c1_ra_in;

   assign c1_da_in = DA_W'(c0_pd_ff[0]) + DA_W'(c0_pd_ff[1]) + DA_W'(c0_pd_ff[2]);
   assign c1_ra_in = RA_W'(c0_pr_ff[0]) + RA_W'(c0_pr_ff[1]) + RA_W'(c0_pr_ff[2]);

   // C2: (D.V) * t
   logic                   c2_v_ff;
   geo_type                c2_geo_ff;
   logic                   c2_z_ff;
   logic signed [OW-1:0]   c2_ax_ff [3];
   logic signed [RA_W-1:0] c2_ra_ff;
   logic signed [DT_W-1:0] c2_dat_ff, c2_dat_in;

   assign c2_dat_in = c1_da_ff * $signed({1'b0, c1_geo_ff.t});

   // C3: m = trunc((D.V) t) + (O-C).V
   logic                  c3_v_ff;
   geo_type               c3_geo_ff;
   logic                  c3_z_ff;
   logic signed [OW-1:0]  c3_ax_ff [3];
   logic signed [M_W-1:0] c3_m_ff, c3_m_in;

   always_comb begin
      logic signed [M_W-1:0] ext;
      logic signed [M_W-1:0] bias;
      ext     = M_W'(c2_dat_ff);
      bias    = c2_dat_ff[DT_W-1] ? ((M_W'(1) <<< FRAC_BITS) - M_W'(1)) : '0;
      c3_m_in = ((ext + bias) >>> FRAC_BITS) + M_W'(c2_ra_ff);
   end

   // C4: axis times truncated m
   logic                   c4_v_ff;
   geo_type                c4_geo_ff;
   logic                   c4_z_ff;
   logic signed [PA_W-1:0] c4_pa_ff [3];
   logic signed [PA_W-1:0] c4_pa_in [3];

   always_comb begin
      logic signed [M_W-1:0]  bias;
      logic signed [M_W-1:0]  full;
      logic signed [MF_W-1:0] mf;
      bias = c3_m_ff[M_W-1] ? ((M_W'(1) <<< NF) - M_W'(1)) : '0;
      full = (c3_m_ff + bias) >>> NF;
      mf   = MF_W'(full);
      for (int i = 0; i < 3; i++) begin
         c4_pa_in[i] = mf * c3_ax_ff[i];
      end
   end

   // C5: radial vector and choice of the vector to normalize
   logic                  c5_v_ff;
   fin_type               c5_fin_ff, c5_fin_in;
   logic signed [VW2-1:0] c5_vec_ff [3];
   logic signed [VW2-1:0] c5_vec_in [3];

   always_comb begin
      logic signed [PA_W-1:0] bias;
      logic signed [PA_W-1:0] pt;
      logic signed [RW-1:0]   wc;
      c5_fin_in.kind = c4_geo_ff.kind;
      c5_fin_in.dir  = c4_geo_ff.dir;
      c5_fin_in.b    = c4_geo_ff.b;
      c5_fin_in.deg1 = c4_z_ff;
      for (int i = 0; i < 3; i++) begin
         bias = c4_pa_ff[i][PA_W-1] ? ((PA_W'(1) <<< NF) - PA_W'(1)) : '0;
         pt   = (c4_pa_ff[i] + bias) >>> NF;
         wc   = RW'($signed(c4_geo_ff.hma[i])) - RW'(pt);
         case (c4_geo_ff.kind)
            snu_pkg::KIND_TRIANGLE: c5_vec_in[i] = VW2'($signed(c4_geo_ff.wx[i]));
            snu_pkg::KIND_SPHERE:   c5_vec_in[i] = VW2'($signed(c4_geo_ff.hma[i]));
            snu_pkg::KIND_CYLINDER: c5_vec_in[i] = VW2'(wc);
            default:                c5_vec_in[i] = '0;
         endcase
      end
   end

   // final normalizer
   logic                 n2_v;
   logic signed [OW-1:0] n2_n [3];
   logic                 n2_zero;
   fin_type              n2_fin;

   snu_norm #(
      .VEC_W  (VW2),
      .SIDE_W ($bits(fin_type))
   ) u_norm_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c5_v_ff),
      .in_vec    (c5_vec_ff),
      .in_side   (c5_fin_ff),
      .out_valid (n2_v),
      .out_vec   (n2_n),
      .out_zero  (n2_zero),
      .out_side  (n2_fin)
   );

   // F0: normal per kind and facing products
   logic                   f0_v_ff;
   logic signed [PQ_W-1:0] f0_pre_ff [3];
   logic signed [PQ_W-1:0] f0_pre_in [3];
   logic signed [TP_W-1:0] f0_tp_ff [3];
   logic signed [TP_W-1:0] f0_tp_in [3];
   logic                   f0_deg_ff, f0_deg_in;
   logic                   f0_face_ff, f0_face_in;

   always_comb begin
      logic signed [PQ_W-1:0] ext;
      logic signed [PQ_W-1:0] bias;
      logic signed [CW-1:0]   bc;
      logic signed [CW-1:0]   dc;
      f0_deg_in  = 1'b0;
      f0_face_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         bc   = n2_fin.b[i];
         dc   = n2_fin.dir[i];
         ext  = PQ_W'(bc) <<< UP;
         bias = ext[PQ_W-1] ? ((PQ_W'(1) <<< DN) - PQ_W'(1)) : '0;
         f0_pre_in[i] = '0;
         f0_tp_in[i]  = '0;
         if (n2_fin.kind inside {snu_pkg::KIND_PLANE, snu_pkg::KIND_SQUARE}) begin
            f0_pre_in[i] = (ext + bias) >>> DN;
            f0_tp_in[i]  = bc * dc;
         end else if (n2_fin.kind == snu_pkg::KIND_CYLINDER) begin
            if (!n2_fin.deg1) begin
               f0_pre_in[i] = PQ_W'(n2_n[i]);
               f0_tp_in[i]  = n2_n[i] * dc;
            end
         end else if (n2_fin.kind inside {snu_pkg::KIND_TRIANGLE, snu_pkg::KIND_SPHERE}) begin
            f0_pre_in[i] = PQ_W'(n2_n[i]);
            f0_tp_in[i]  = n2_n[i] * dc;
         end
      end
      case (n2_fin.kind)
         snu_pkg::KIND_TRIANGLE: f0_deg_in = n2_zero;
         snu_pkg::KIND_SPHERE: begin
            f0_deg_in  = n2_zero;
            f0_face_in = 1'b0;
         end
         snu_pkg::KIND_PLANE:    f0_deg_in = 1'b0;
         snu_pkg::KIND_SQUARE:   f0_deg_in = 1'b0;
         snu_pkg::KIND_CYLINDER: f0_deg_in = n2_fin.deg1 | n2_zero;
         default:                f0_deg_in = 1'b1;
      endcase
   end

   // F1: flip against the ray, saturate
   logic             f1_v_ff;
   snu_pkg::rsp_type f1_rsp_ff, f1_rsp_in;

   always_comb begin
      logic signed [DOT_W-1:0] dot;
      logic                    flip;
      logic signed [PQ_W:0]    val;
      logic signed [OW-1:0]    sat [3];
      dot  = DOT_W'(f0_tp_ff[0]) + DOT_W'(f0_tp_ff[1]) + DOT_W'(f0_tp_ff[2]);
      flip = f0_face_ff && (dot > 0);
      for (int i = 0; i < 3; i++) begin
         val = flip ? -((PQ_W + 1)'(f0_pre_ff[i])) : (PQ_W + 1)'(f0_pre_ff[i]);
         if (val > SAT_HI) begin
            sat[i] = OW'(SAT_HI);
         end else if (val < SAT_LO) begin
            sat[i] = OW'(SAT_LO);
         end else begin
            sat[i] = OW'(val);
         end
      end
      f1_rsp_in.normal_x   = sat[0];
      f1_rsp_in.normal_y   = sat[1];
      f1_rsp_in.normal_z   = sat[2];
      f1_rsp_in.degenerate = f0_deg_ff;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      t1_geo_ff <= t1_geo_in;
      t1_u_ff   <= t1_u_in;
      t1_w_ff   <= t1_w_in;
      t2_geo_ff <= t1_geo_ff;
      t2_p_ff   <= t2_p_in;
      t3_geo_ff <= t3_geo_in;
      c0_geo_ff <= n1_geo;
      c0_z_ff   <= n1_zero;
      c0_ax_ff  <= n1_ax;
      c0_pd_ff  <= c0_pd_in;
      c0_pr_ff  <= c0_pr_in;
      c1_geo_ff <= c0_geo_ff;
      c1_z_ff   <= c0_z_ff;
      c1_ax_ff  <= c0_ax_ff;
      c1_da_ff  <= c1_da_in;
      c1_ra_ff  <= c1_ra_in;
      c2_geo_ff <= c1_geo_ff;
      c2_z_ff   <= c1_z_ff;
      c2_ax_ff  <= c1_ax_ff;
      c2_ra_ff  <= c1_ra_ff;
      c2_dat_ff <= c2_dat_in;
      c3_geo_ff <= c2_geo_ff;
      c3_z_ff   <= c2_z_ff;
      c3_ax_ff  <= c2_ax_ff;
      c3_m_ff   <= c3_m_in;
      c4_geo_ff <= c3_geo_ff;
      c4_z_ff   <= c3_z_ff;
      c4_pa_ff  <= c4_pa_in;
      c5_fin_ff <= c5_fin_in;
      c5_vec_ff <= c5_vec_in;
      f0_pre_ff  <= f0_pre_in;
      f0_tp_ff   <= f0_tp_in;
      f0_deg_ff  <= f0_deg_in;
      f0_face_ff <= f0_face_in;
      f1_rsp_ff  <= f1_rsp_in;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         t0_v_ff <= 1'b0;
         t1_v_ff <= 1'b0;
         t2_v_ff <= 1'b0;
         t3_v_ff <= 1'b0;
         c0_v_ff <= 1'b0;
         c1_v_ff <= 1'b0;
         c2_v_ff <= 1'b0;
         c3_v_ff <= 1'b0;
         c4_v_ff <= 1'b0;
         c5_v_ff <= 1'b0;
         f0_v_ff <= 1'b0;
         f1_v_ff <= 1'b0;
      end else begin
         t0_v_ff <= accept;
         t1_v_ff <= t0_v_ff;
         t2_v_ff <= t1_v_ff;
         t3_v_ff <= t2_v_ff;
         c0_v_ff <= n1_v;
         c1_v_ff <= c0_v_ff;
         c2_v_ff <= c1_v_ff;
         c3_v_ff <= c2_v_ff;
         c4_v_ff <= c3_v_ff;
         c5_v_ff <= c4_v_ff;
         f0_v_ff <= n2_v;
         f1_v_ff <= f0_v_ff;
      end
   end

   assign rsp_valid = f1_v_ff;
   assign rsp_data  = f1_rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/snu_norm.sv
`default_nettype none

// Pipelined vector normalizer: magnitude scaling, one sqrt bit per stage,
// one quotient bit per stage; one vector per cycle.
module snu_norm #(
   parameter int VEC_W  = 50,
   parameter int SIDE_W = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   input  wire logic signed [VEC_W-1:0]              in_vec [3],
   input  wire logic [SIDE_W-1:0]                    in_side,
   output logic                                      out_valid,
   output logic signed [snu_pkg::OUT_WIDTH-1:0]      out_vec [3],
   output logic                                      out_zero,
   output logic [SIDE_W-1:0]                         out_side
);

   localparam int A_W        = 30;
   localparam int MAG_W      = (VEC_W > A_W) ? VEC_W : A_W;
   localparam int SH_W       = $clog2(MAG_W + 1);
   localparam int SQ_W       = 2 * A_W;
   localparam int SUM_W      = 2 * A_W + 3;
   localparam int ROOT_W     = A_W + 1;
   localparam int ROOT_STEPS = A_W + 1;
   localparam int Q_BITS     = snu_pkg::NORM_FRAC + 1;
   localparam int D_W        = ROOT_W + 1;
   localparam int DIV_W      = A_W + Q_BITS + 2;
   localparam int OW         = snu_pkg::OUT_WIDTH;

   typedef struct packed {
      logic [2:0]          sgn;
      logic                zero;
      logic [2:0][A_W-1:0] a;
      logic [SIDE_W-1:0]   side;
   } carry_type;

   // stage 0: magnitudes and signs
   logic              s0_v_ff;
   logic [MAG_W-1:0]  s0_mag_ff [3];
   logic [MAG_W-1:0]  s0_mag_in [3];
   logic [2:0]        s0_sgn_ff, s0_sgn_in;
   logic [SIDE_W-1:0] s0_side_ff;

   always_comb begin
      logic [VEC_W-1:0] raw;
      logic [VEC_W-1:0] absv;
      for (int i = 0; i < 3; i++) begin
         raw  = in_vec[i];
         absv = raw[VEC_W-1] ? (~raw + 1'b1) : raw;
         s0_sgn_in[i] = raw[VEC_W-1];
         s0_mag_in[i] = MAG_W'(absv);
      end
   end

   // stage 1: scale shift from the highest set bit of all magnitudes
   logic              s1_v_ff;
   logic [MAG_W-1:0]  s1_mag_ff [3];
   logic [2:0]        s1_sgn_ff;
   logic [SIDE_W-1:0] s1_side_ff;
   logic [SH_W-1:0]   s1_sh_ff, s1_sh_in;
   logic              s1_zero_ff, s1_zero_in;

   always_comb begin
      logic [MAG_W-1:0] orv;
      logic [SH_W-1:0]  hi;
      orv = s0_mag_ff[0] | s0_mag_ff[1] | s0_mag_ff[2];
      hi  = '0;
      for (int j = 0; j < MAG_W; j++) begin
         if (orv[j]) begin
            hi = SH_W'(j + 1);
         end
      end
      s1_zero_in = (orv == '0);
      s1_sh_in   = (hi > SH_W'(A_W)) ? (hi - SH_W'(A_W)) : '0;
   end

   // stage 2: scaled magnitudes
   logic      s2_v_ff;
   carry_type s2_c_ff, s2_c_in;

   always_comb begin
      s2_c_in.sgn  = s1_sgn_ff;
      s2_c_in.zero = s1_zero_ff;
      s2_c_in.side = s1_side_ff;
      for (int i = 0; i < 3; i++) begin
         s2_c_in.a[i] = A_W'(s1_mag_ff[i] >> s1_sh_ff);
      end
   end

   // stage 3: squares
   logic            s3_v_ff;
   carry_type       s3_c_ff;
   logic [SQ_W-1:0] s3_sq_ff [3];
   logic [SQ_W-1:0] s3_sq_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_sq_in[i] = SQ_W'(s2_c_ff.a[i]) * SQ_W'(s2_c_ff.a[i]);
      end
   end

   // square root: entry 0 holds the sum, then one result bit per stage
   logic             rv_ff [ROOT_STEPS+1];
   carry_type        rc_ff [ROOT_STEPS+1];
   logic [SUM_W-1:0] rx_ff [ROOT_STEPS+1];
   logic [SUM_W-1:0] rx_in [ROOT_STEPS+1];
   logic [SUM_W-1:0] rr_ff [ROOT_STEPS+1];
   logic [SUM_W-1:0] rr_in [ROOT_STEPS+1];

   always_comb begin
      logic [SUM_W-1:0] bitv;
      logic [SUM_W-1:0] trial;
      rx_in[0] = SUM_W'(s3_sq_ff[0]) + SUM_W'(s3_sq_ff[1]) + SUM_W'(s3_sq_ff[2]);
      rr_in[0] = '0;
      for (int k = 0; k < ROOT_STEPS; k++) begin
         bitv  = SUM_W'(1) << (2 * (ROOT_STEPS - 1 - k));
         trial = rr_ff[k] + bitv;
         if (rx_ff[k] >= trial) begin
            rx_in[k+1] = rx_ff[k] - trial;
            rr_in[k+1] = (rr_ff[k] >> 1) + bitv;
         end else begin
            rx_in[k+1] = rx_ff[k];
            rr_in[k+1] = rr_ff[k] >> 1;
         end
      end
   end

   // division: (a * 2^15 + r) / (2r), one quotient bit per stage
   logic              dv_ff [Q_BITS+1];
   carry_type         dc_ff [Q_BITS+1];
   logic [D_W-1:0]    dd_ff [Q_BITS+1];
   logic [D_W-1:0]    dd_in0;
   logic [DIV_W-1:0]  dn_ff [Q_BITS+1][3];
   logic [DIV_W-1:0]  dn_in [Q_BITS+1][3];
   logic [Q_BITS-1:0] dq_ff [Q_BITS+1][3];
   logic [Q_BITS-1:0] dq_in [Q_BITS+1][3];

   always_comb begin
      logic [ROOT_W-1:0] root;
      logic [DIV_W-1:0]  trial;
      root   = rr_ff[ROOT_STEPS][ROOT_W-1:0];
      dd_in0 = {root, 1'b0};
      for (int i = 0; i < 3; i++) begin
         dn_in[0][i] = (DIV_W'(rc_ff[ROOT_STEPS].a[i]) << Q_BITS) + DIV_W'(root);
         dq_in[0][i] = '0;
      end
      for (int j = 0; j < Q_BITS; j++) begin
         trial = DIV_W'(dd_ff[j]) << (Q_BITS - 1 - j);
         for (int i = 0; i < 3; i++) begin
            if (dn_ff[j][i] >= trial) begin
               dn_in[j+1][i] = dn_ff[j][i] - trial;
               dq_in[j+1][i] = dq_ff[j][i] | (Q_BITS'(1) << (Q_BITS - 1 - j));
            end else begin
               dn_in[j+1][i] = dn_ff[j][i];
               dq_in[j+1][i] = dq_ff[j][i];
            end
         end
      end
   end

   // output stage: restore signs
   logic                 o_v_ff;
   logic signed [OW-1:0] o_vec_ff [3];
   logic signed [OW-1:0] o_vec_in [3];
   logic                 o_zero_ff;
   logic [SIDE_W-1:0]    o_side_ff;

   always_comb begin
      logic signed [OW-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = OW'(dq_ff[Q_BITS][i]);
         if (dc_ff[Q_BITS].zero) begin
            o_vec_in[i] = '0;
         end else if (dc_ff[Q_BITS].sgn[i]) begin
            o_vec_in[i] = -q;
         end else begin
            o_vec_in[i] = q;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s0_mag_ff  <= s0_mag_in;
      s0_sgn_ff  <= s0_sgn_in;
      s0_side_ff <= in_side;
      s1_mag_ff  <= s0_mag_ff;
      s1_sgn_ff  <= s0_sgn_ff;
      s1_side_ff <= s0_side_ff;
      s1_sh_ff   <= s1_sh_in;
      s1_zero_ff <= s1_zero_in;
      s2_c_ff    <= s2_c_in;
      s3_c_ff    <= s2_c_ff;
      s3_sq_ff   <= s3_sq_in;
      rc_ff[0]   <= s3_c_ff;
      rx_ff[0]   <= rx_in[0];
      rr_ff[0]   <= rr_in[0];
      for (int k = 0; k < ROOT_STEPS; k++) begin
         rc_ff[k+1] <= rc_ff[k];
         rx_ff[k+1] <= rx_in[k+1];
         rr_ff[k+1] <= rr_in[k+1];
      end
      dc_ff[0] <= rc_ff[ROOT_STEPS];
      dd_ff[0] <= dd_in0;
      for (int j = 0; j <= Q_BITS; j++) begin
         dn_ff[j] <= dn_in[j];
         dq_ff[j] <= dq_in[j];
      end
      for (int j = 0; j < Q_BITS; j++) begin
         dc_ff[j+1] <= dc_ff[j];
         dd_ff[j+1] <= dd_ff[j];
      end
      o_vec_ff  <= o_vec_in;
      o_zero_ff <= dc_ff[Q_BITS].zero;
      o_side_ff <= dc_ff[Q_BITS].side;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         for (int k = 0; k <= ROOT_STEPS; k++) begin
            rv_ff[k] <= 1'b0;
         end
         for (int j = 0; j <= Q_BITS; j++) begin
            dv_ff[j] <= 1'b0;
         end
         o_v_ff <= 1'b0;
      end else begin
         s0_v_ff  <= in_valid;
         s1_v_ff  <= s0_v_ff;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         rv_ff[0] <= s3_v_ff;
         for (int k = 0; k < ROOT_STEPS; k++) begin
            rv_ff[k+1] <= rv_ff[k];
         end
         dv_ff[0] <= rv_ff[ROOT_STEPS];
         for (int j = 0; j < Q_BITS; j++) begin
            dv_ff[j+1] <= dv_ff[j];
         end
         o_v_ff <= dv_ff[Q_BITS];
      end
   end

   assign out_valid = o_v_ff;
   assign out_vec   = o_vec_ff;
   assign out_zero  = o_zero_ff;
   assign out_side  = o_side_ff;

endmodule

`default_nettype wire
